### hw/rtl/ise_pkg.sv
// Shared payload, command and status types for the insertion sort engine.
package ise_pkg;

   localparam int unsigned ValueWidth = 32;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic                         last_item;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] sorted_value;
      logic                         last_of_run;
      logic                         dropped;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic shift_out;
   } cmd_type;

   typedef struct packed {
      logic run_last;
   } status_type;

endpackage

### hw/rtl/ise_ctrl.sv
// Controller state machine that sequences insertion and the output run.
module ise_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_item,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ise_pkg::status_type  status,
   output ise_pkg::cmd_type     cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.insert    = 1'b0;
      cmd.shift_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.insert = req_valid;
            if (req_valid && req_last_item) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.shift_out = !rsp_stall;
            if (!rsp_stall && status.run_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff == ST_DRAIN);
   assign rsp_valid = (state_ff == ST_DRAIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/ise_datapath.sv
// Row of compare-and-shift slots holding the ordered list, with count and overflow flag.
module ise_datapath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ise_pkg::req_type     req_data,
   input  ise_pkg::cmd_type     cmd,
   output ise_pkg::status_type  status,
   output ise_pkg::rsp_type     rsp_data
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic signed [ise_pkg::ValueWidth-1:0] held_ff [CAPACITY];
   logic signed [ise_pkg::ValueWidth-1:0] held_in [CAPACITY];
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                overflow_ff;
   logic                overflow_in;
   logic [CAPACITY-1:0] take;
   logic                full;

   assign full = (count_ff == CW'(CAPACITY));

   // A slot takes part in the insertion when it is empty or holds a value
   // strictly greater than the arrival, so equal values keep arrival order.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         take[i] = (CW'(i) >= count_ff) || (held_ff[i] > req_data.value);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         held_in[i] = held_ff[i];
      end
      if (cmd.insert && !full) begin
         if (take[0]) begin
            held_in[0] = req_data.value;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (take[i]) begin
               held_in[i] = take[i-1] ? held_ff[i-1] : req_data.value;
            end
         end
      end else if (cmd.shift_out) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            held_in[i] = held_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.insert) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (cmd.shift_out) begin
         count_in = count_ff - CW'(1);
         if (status.run_last) begin
            overflow_in = 1'b0;
         end
      end
   end

   assign status.run_last = (count_ff == CW'(1));

   assign rsp_data.sorted_value = held_ff[0];
   assign rsp_data.last_of_run  = status.run_last;
   assign rsp_data.dropped      = overflow_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         held_ff[i] <= held_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

### hw/rtl/insertion_sort_engine.sv
// Top level of the insertion sort engine: controller plus slot datapath.
//
// The request channel (req_valid, req_stall, req_data) takes one signed
// 32-bit value per item. Each value is placed into an ascending list held
// in a row of CAPACITY compare-and-shift slots, so an insertion completes
// in the cycle it is accepted and items may arrive back to back, one per
// clock. Equal values keep their arrival order.
// An item with last_item set ends the set. From the next cycle on the
// engine stalls the request channel and presents the held values in
// ascending order on the response channel (rsp_valid, rsp_stall, rsp_data),
// one item per cycle while the receiver does not stall; last_of_run marks
// the end of the run.
// If more than CAPACITY values arrive in one set the extra ones are dropped
// and every item of that run carries the dropped flag.
// A stalled response holds its value; the slot row simply waits. After the
// final item is taken the count and the dropped flag clear and requests are
// accepted again in the following cycle.
// Reset clears the count, the dropped flag and the controller; the slot
// contents are left as they are since only filled slots are ever read.
module insertion_sort_engine #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ise_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ise_pkg::rsp_type  rsp_data
);

   // Commands from the controller and the datapath's run status.
   ise_pkg::cmd_type    cmd;
   ise_pkg::status_type status;

   ise_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_data.last_item),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   ise_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

### hw/rtl/ise_checker.sv
// Port-level checker for the insertion sort engine and its bind statement.
module ise_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ise_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ise_pkg::rsp_type  rsp_data
);

   // Requests are refused exactly while a run is being delivered.
   a_stall_while_run : assert property (@(posedge clock) disable iff (reset)
      req_stall == rsp_valid)
      else $error("request stall does not match run in progress");

   // A last item starts a run in the next cycle.
   a_last_starts_run : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.last_item) |=> rsp_valid)
      else $error("run did not start after last item");

   // Any other item produces nothing.
   a_plain_item_quiet : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_data.last_item) |=> !rsp_valid)
      else $error("result appeared after a non-last item");

   // The run ends right after its final item is taken.
   a_run_ends : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_of_run) |=> !rsp_valid)
      else $error("run continued past its final item");

   // Within a run, delivery continues and the dropped flag stays the same.
   a_run_continues : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_of_run) |=>
         (rsp_valid && rsp_data.dropped == $past(rsp_data.dropped)))
      else $error("run broke off or dropped flag changed");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
